FILE: hdl/mspf_pkg.sv
// ----------------------------------------------------------------------------
// mspf_pkg
// Shared types and constants of the magnetometer sample frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mspf_pkg;

  // payload length of a sample frame and the byte offsets of its fields
  localparam int SAMPLE_LEN = 20;
  localparam int IDX_W      = $clog2(SAMPLE_LEN);
  localparam int AXIS_X_AT  = 0;
  localparam int AXIS_Y_AT  = 4;
  localparam int AXIS_Z_AT  = 8;
  localparam int STAMP_AT   = 12;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MSG_ID   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SKIP_LENGTH = 2'd3;

  localparam logic [7:0]  RST_SYNC_FIRST      = 8'd209;
  localparam logic [7:0]  RST_SYNC_SECOND     = 8'd29;
  localparam logic [7:0]  RST_SAMPLE_MSG_ID   = 8'd1;
  localparam logic [15:0] RST_MAX_SKIP_LENGTH = 16'd1024;

  // result status codes
  localparam logic [1:0] STATUS_INCOMPLETE  = 2'd0;
  localparam logic [1:0] STATUS_SAMPLE      = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH    = 2'd2;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  sample_msg_id;
    logic [15:0] max_skip_length;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic [63:0]        stamp_us;
  } sample_t;

endpackage

`default_nettype wire

FILE: hdl/mspf_if.sv
// ----------------------------------------------------------------------------
// mspf_if
// Valid/ready channels: received byte in, parse result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mspf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mspf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic [63:0]        stamp_us;

  modport source (output valid, output status, output axis_x, output axis_y,
                  output axis_z, output stamp_us, input ready);
  modport sink   (input valid, input status, input axis_x, input axis_y,
                  input axis_z, input stamp_us, output ready);
endinterface

`default_nettype wire

FILE: hdl/mspf_frame_fsm.sv
// ----------------------------------------------------------------------------
// mspf_frame_fsm
// Frame state machine: sync hunt, header, payload and Fletcher-8 check.
// ----------------------------------------------------------------------------
`default_nettype none

module mspf_frame_fsm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         rx_byte,
  input  wire mspf_pkg::cfg_t     cfg,
  output mspf_pkg::store_wr_t     wr,
  output logic [1:0]              status
);

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_ID, PH_LEN1, PH_LEN2, PH_PAY, PH_CKA, PH_CKB
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] byte_index, byte_index_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;

  logic [7:0]  sum_a_upd;
  logic [7:0]  sum_b_upd;
  logic [15:0] len_full;
  logic [15:0] index_inc;
  logic        known;
  logic        clear;

  assign sum_a_upd = sum_a + rx_byte;
  assign sum_b_upd = sum_b + sum_a_upd;
  assign len_full  = {rx_byte, frame_length[7:0]};
  assign index_inc = byte_index + 16'd1;
  assign known     = (frame_id == cfg.sample_msg_id);

  always_comb begin
    phase_next        = phase;
    frame_id_next     = frame_id;
    frame_length_next = frame_length;
    byte_index_next   = byte_index;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    clear             = 1'b0;
    status            = mspf_pkg::STATUS_INCOMPLETE;
    wr.en             = 1'b0;
    wr.addr           = byte_index[mspf_pkg::IDX_W-1:0];
    wr.data           = rx_byte;

    case (phase)
      PH_SYNC1: begin
        if (rx_byte == cfg.sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          sum_a_next = 8'd0;
          sum_b_next = 8'd0;
          phase_next = PH_ID;
        end else if (rx_byte == cfg.sync_first) begin
          phase_next = PH_SYNC2;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_ID: begin
        frame_id_next = rx_byte;
        sum_a_next    = sum_a_upd;
        sum_b_next    = sum_b_upd;
        phase_next    = PH_LEN1;
      end
      PH_LEN1: begin
        frame_length_next = {8'd0, rx_byte};
        sum_a_next        = sum_a_upd;
        sum_b_next        = sum_b_upd;
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        frame_length_next = len_full;
        sum_a_next        = sum_a_upd;
        sum_b_next        = sum_b_upd;
        byte_index_next   = 16'd0;
        // wrongly sized sample frame or oversized unknown frame is dropped
        if ((known && len_full != 16'(mspf_pkg::SAMPLE_LEN)) ||
            (!known && len_full > cfg.max_skip_length)) begin
          clear = 1'b1;
        end else if (len_full == 16'd0) begin
          phase_next = PH_CKA;
        end else begin
          phase_next = PH_PAY;
        end
      end
      PH_PAY: begin
        sum_a_next      = sum_a_upd;
        sum_b_next      = sum_b_upd;
        wr.en           = known && (byte_index < 16'(mspf_pkg::SAMPLE_LEN));
        byte_index_next = index_inc;
        if (index_inc == frame_length) phase_next = PH_CKA;
      end
      PH_CKA: begin
        if (rx_byte != sum_a) begin
          clear  = 1'b1;
          status = mspf_pkg::STATUS_MISMATCH;
        end else begin
          phase_next = PH_CKB;
        end
      end
      PH_CKB: begin
        clear = 1'b1;
        if (rx_byte != sum_b) status = mspf_pkg::STATUS_MISMATCH;
        else if (!known)      status = mspf_pkg::STATUS_UNSUPPORTED;
        else                  status = mspf_pkg::STATUS_SAMPLE;
      end
      default: begin
        clear = 1'b1;
      end
    endcase

    // frame end or drop: back to the hunt with a clean header
    if (clear) begin
      phase_next        = PH_SYNC1;
      frame_id_next     = 8'd0;
      frame_length_next = 16'd0;
      byte_index_next   = 16'd0;
      sum_a_next        = 8'd0;
      sum_b_next        = 8'd0;
    end

    if (!accept) wr.en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      frame_id     <= 8'd0;
      frame_length <= 16'd0;
      byte_index   <= 16'd0;
      sum_a        <= 8'd0;
      sum_b        <= 8'd0;
    end else if (accept) begin
      phase        <= phase_next;
      frame_id     <= frame_id_next;
      frame_length <= frame_length_next;
      byte_index   <= byte_index_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mspf_sample_store.sv
// ----------------------------------------------------------------------------
// mspf_sample_store
// Payload bytes of the current sample frame and their little-endian decode.
// ----------------------------------------------------------------------------
`default_nettype none

module mspf_sample_store (
  input  wire logic                clk,
  input  wire mspf_pkg::store_wr_t wr,
  output mspf_pkg::sample_t        sample
);

  logic [7:0] mem [mspf_pkg::SAMPLE_LEN];

  // no reset: contents only read once a full sample payload has been written
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sample.axis_x[8*k +: 8] = mem[mspf_pkg::AXIS_X_AT + k];
      sample.axis_y[8*k +: 8] = mem[mspf_pkg::AXIS_Y_AT + k];
      sample.axis_z[8*k +: 8] = mem[mspf_pkg::AXIS_Z_AT + k];
    end
    for (int k = 0; k < 8; k++) begin
      sample.stamp_us[8*k +: 8] = mem[mspf_pkg::STAMP_AT + k];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mag_sample_frame_parser_unit.sv
// latency: a result word is valid in the cycle after its byte is accepted
// throughput: one byte per cycle unless stalled; frame state and checksum update
// in one step. The result register frees as it is taken, so input and output
// can move together; reset clears the registers to their defaults, the parser to
// sync hunt and the result register to empty; stored sample bytes are not cleared
// ----------------------------------------------------------------------------
// mag_sample_frame_parser_unit
// Framed magnetometer packet parser with Fletcher-8 check, one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mag_sample_frame_parser_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mspf_in_if.sink                              rx,
  mspf_out_if.source                           res,
  input  wire logic                            cfg_we,
  input  wire logic [mspf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mspf_pkg::CFG_DATA_W-1:0] cfg_data
);

  mspf_pkg::cfg_t      cfg;
  mspf_pkg::store_wr_t wr;
  mspf_pkg::sample_t   sample;
  logic [1:0]          status;
  logic                accept;

  assign rx.ready = !res.valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first      <= mspf_pkg::RST_SYNC_FIRST;
      cfg.sync_second     <= mspf_pkg::RST_SYNC_SECOND;
      cfg.sample_msg_id   <= mspf_pkg::RST_SAMPLE_MSG_ID;
      cfg.max_skip_length <= mspf_pkg::RST_MAX_SKIP_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        mspf_pkg::REG_SYNC_FIRST:      cfg.sync_first      <= cfg_data[7:0];
        mspf_pkg::REG_SYNC_SECOND:     cfg.sync_second     <= cfg_data[7:0];
        mspf_pkg::REG_SAMPLE_MSG_ID:   cfg.sample_msg_id   <= cfg_data[7:0];
        mspf_pkg::REG_MAX_SKIP_LENGTH: cfg.max_skip_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mspf_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .wr      (wr),
    .status  (status)
  );

  mspf_sample_store u_store (
    .clk    (clk),
    .wr     (wr),
    .sample (sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // result payload, sample fields zero unless a good sample frame closed
  always_ff @(posedge clk) begin
    if (accept) begin
      res.status <= status;
      if (status == mspf_pkg::STATUS_SAMPLE) begin
        res.axis_x   <= sample.axis_x;
        res.axis_y   <= sample.axis_y;
        res.axis_z   <= sample.axis_z;
        res.stamp_us <= sample.stamp_us;
      end else begin
        res.axis_x   <= 32'sd0;
        res.axis_y   <= 32'sd0;
        res.axis_z   <= 32'sd0;
        res.stamp_us <= 64'd0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mspf_checker.sv
// ----------------------------------------------------------------------------
// mspf_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mspf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rx_valid,
  input wire logic        rx_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] axis_x,
  input wire logic [31:0] axis_y,
  input wire logic [31:0] axis_z,
  input wire logic [63:0] stamp_us
);

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid after reset");

  // every accepted byte gives a result word in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready |=> res_valid)
    else $error("accepted byte gave no result");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready)
    else $error("input stalled with empty result register");

  // sample fields are zero unless a sample is reported
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != mspf_pkg::STATUS_SAMPLE |->
      axis_x == 32'd0 && axis_y == 32'd0 && axis_z == 32'd0 && stamp_us == 64'd0)
    else $error("sample fields set on a non-sample result");

  // a stalled result word holds its status and time stamp
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(stamp_us))
    else $error("stalled result changed");

endmodule

bind mag_sample_frame_parser_unit mspf_checker u_mspf_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_valid  (rx.valid),
  .rx_ready  (rx.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .status    (res.status),
  .axis_x    (res.axis_x),
  .axis_y    (res.axis_y),
  .axis_z    (res.axis_z),
  .stamp_us  (res.stamp_us)
);

`default_nettype wire
